// File: rtl/piecewise_linear_curve_eval_top_defines.svh
// Assertion macros shared by the curve evaluator RTL.
`ifndef PIECEWISE_LINEAR_CURVE_EVAL_TOP_DEFINES_SVH
`define PIECEWISE_LINEAR_CURVE_EVAL_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define PWL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("pwl assertion failed");

// Check that a condition in one cycle is followed by another in the next.
`define PWL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pwl assertion failed");

`else

`define PWL_ASSERT(lbl, clk, rst, prop)
`define PWL_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: rtl/pwl_pkg.sv
`default_nettype none

package pwl_pkg;

   // Table geometry
   localparam int MaxPoints  = 16;
   localparam int IdxWidth   = $clog2(MaxPoints);
   localparam int CountWidth = $clog2(MaxPoints + 1);

   // Q16.16 arithmetic
   localparam int DataWidth  = 32;
   localparam int FracBits   = 16;
   localparam int WeightBits = FracBits + 1;
   localparam int StepWidth  = $clog2(WeightBits + 1);
   localparam int ProdWidth  = (DataWidth + 1) + (WeightBits + 1);
   localparam logic [DataWidth-1:0] FactorOne = DataWidth'(1) << FracBits;

   // Item modes
   localparam logic ModeWrite = 1'b0;
   localparam logic ModeEval  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV,
      ST_MUL,
      ST_OUT
   } pwl_state_type;

   typedef enum logic [1:0] {
      SRC_ONE,
      SRC_CUR,
      SRC_INTERP
   } pwl_src_type;

   typedef struct packed {
      logic                capture;
      logic                mem_we;
      logic                rd_en;
      logic [IdxWidth-1:0] rd_addr;
      logic                prev_load;
      logic                div_start;
      logic                mul_load;
      logic                out_load;
      pwl_src_type         out_src;
   } pwl_cmd_type;

   typedef struct packed {
      logic le;
      logic div_busy;
   } pwl_stat_type;

endpackage

`default_nettype wire

// File: rtl/pwl_if.sv
`default_nettype none

// Request channel: breakpoint writes and evaluate items
interface pwl_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  mode;
   logic        [pwl_pkg::IdxWidth-1:0]   point_index;
   logic signed [pwl_pkg::DataWidth-1:0]  point_time;
   logic signed [pwl_pkg::DataWidth-1:0]  point_value;
   logic signed [pwl_pkg::DataWidth-1:0]  query_time;

   modport source (
      output valid, mode, point_index, point_time, point_value, query_time,
      input  ready
   );
   modport sink (
      input  valid, mode, point_index, point_time, point_value, query_time,
      output ready
   );
endinterface

// Response channel: one factor per evaluate item
interface pwl_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [pwl_pkg::DataWidth-1:0]  factor;

   modport source (output valid, factor, input ready);
   modport sink (input valid, factor, output ready);
endinterface

`default_nettype wire

// File: rtl/pwl_div.sv
`default_nettype none
`include "piecewise_linear_curve_eval_top_defines.svh"

module pwl_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [pwl_pkg::DataWidth-1:0]   dividend,
   input  wire logic [pwl_pkg::DataWidth-1:0]   divisor,
   output logic                                 busy,
   output logic [pwl_pkg::WeightBits-1:0]       quotient
);

   logic                                busy_ff, busy_in;
   logic [pwl_pkg::StepWidth-1:0]       cnt_ff, cnt_in;
   logic [pwl_pkg::DataWidth:0]         rem_ff, rem_in;
   logic [pwl_pkg::DataWidth-1:0]       den_ff, den_in;
   logic [pwl_pkg::WeightBits-1:0]      quo_ff, quo_in;
   logic                                first;
   logic [pwl_pkg::DataWidth:0]         trial;
   logic                                ge;

   // One restoring step a cycle; the first step compares without a shift
   always_comb begin
      first   = (cnt_ff == pwl_pkg::StepWidth'(pwl_pkg::WeightBits));
      trial   = first ? rem_ff : {rem_ff[pwl_pkg::DataWidth-1:0], 1'b0};
      ge      = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = pwl_pkg::StepWidth'(pwl_pkg::WeightBits);
         rem_in  = {1'b0, dividend};
         den_in  = divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? (trial - {1'b0, den_ff}) : trial;
         quo_in  = {quo_ff[pwl_pkg::WeightBits-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != pwl_pkg::StepWidth'(1));
      end
   end

   // Hold control under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Advance remainder and quotient
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

   `PWL_ASSERT_NEXT(a_div_start, clock, reset, start, busy_ff && first)
   `PWL_ASSERT(a_div_count, clock, reset, busy_ff |-> cnt_ff != '0)
   `PWL_ASSERT(a_div_idle, clock, reset, !busy_ff |-> cnt_ff == '0)

endmodule

`default_nettype wire

// File: rtl/pwl_dp.sv
`default_nettype none

module pwl_dp (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire pwl_pkg::pwl_cmd_type                 cmd,
   output pwl_pkg::pwl_stat_type                     stat,
   input  wire logic        [pwl_pkg::IdxWidth-1:0]  wr_index,
   input  wire logic signed [pwl_pkg::DataWidth-1:0] wr_time,
   input  wire logic signed [pwl_pkg::DataWidth-1:0] wr_value,
   input  wire logic signed [pwl_pkg::DataWidth-1:0] query_time,
   output logic signed      [pwl_pkg::DataWidth-1:0] factor
);

   localparam int W = pwl_pkg::DataWidth;

   logic [2*W-1:0]                        mem_ff [pwl_pkg::MaxPoints];
   logic [2*W-1:0]                        rd_ff;
   logic [W-1:0]                          q_ff;
   logic [W-1:0]                          prev_time_ff;
   logic [W-1:0]                          prev_value_ff;
   logic signed [pwl_pkg::ProdWidth-1:0]  prod_ff, prod_in;
   logic [W-1:0]                          factor_ff, factor_in;

   logic [W-1:0]                          cur_time;
   logic [W-1:0]                          cur_value;
   logic [W:0]                            span;
   logic [W:0]                            offset;
   logic                                  span_pos;
   logic [W-1:0]                          div_num;
   logic [W-1:0]                          div_den;
   logic                                  div_busy;
   logic [pwl_pkg::WeightBits-1:0]        weight;
   logic signed [W:0]                     delta;
   logic signed [pwl_pkg::WeightBits:0]   weight_s;

   // Breakpoint table: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem_ff[wr_index] <= {wr_time, wr_value};
      end
      if (cmd.rd_en) begin
         rd_ff <= mem_ff[cmd.rd_addr];
      end
   end

   assign cur_time  = rd_ff[2*W-1:W];
   assign cur_value = rd_ff[W-1:0];

   // Segment arithmetic on the entry just read and the one before it
   always_comb begin
      span     = {cur_time[W-1], cur_time} - {prev_time_ff[W-1], prev_time_ff};
      offset   = {q_ff[W-1], q_ff} - {prev_time_ff[W-1], prev_time_ff};
      span_pos = !span[W] && (span != '0);
      div_num  = span_pos ? offset[W-1:0] : '0;
      div_den  = span_pos ? span[W-1:0] : W'(1);
      delta    = $signed({cur_value[W-1], cur_value})
                 - $signed({prev_value_ff[W-1], prev_value_ff});
      weight_s = $signed({1'b0, weight});
      prod_in  = delta * weight_s;
   end

   pwl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .busy     (div_busy),
      .quotient (weight)
   );

   // Pick the result: empty curve, a stored value, or the interpolation
   always_comb begin
      case (cmd.out_src)
         pwl_pkg::SRC_ONE:    factor_in = pwl_pkg::FactorOne;
         pwl_pkg::SRC_CUR:    factor_in = cur_value;
         pwl_pkg::SRC_INTERP: factor_in = prev_value_ff
                                          + prod_ff[pwl_pkg::FracBits +: W];
         default:             factor_in = '0;
      endcase
   end

   // Hold query, previous point, product and output register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         q_ff <= query_time;
      end
      if (cmd.prev_load) begin
         prev_time_ff  <= cur_time;
         prev_value_ff <= cur_value;
      end
      if (cmd.mul_load) begin
         prod_ff <= prod_in;
      end
      if (cmd.out_load) begin
         factor_ff <= factor_in;
      end
   end

   assign stat.le       = ($signed(q_ff) <= $signed(cur_time));
   assign stat.div_busy = div_busy;
   assign factor        = factor_ff;

endmodule

`default_nettype wire

// File: rtl/pwl_ctrl.sv
`default_nettype none
`include "piecewise_linear_curve_eval_top_defines.svh"

module pwl_ctrl (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [pwl_pkg::CountWidth-1:0]     csr_wdata,
   input  wire logic                               req_valid,
   input  wire logic                               req_mode,
   output logic                                    req_ready,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output pwl_pkg::pwl_cmd_type                    cmd,
   input  wire pwl_pkg::pwl_stat_type              stat
);

   pwl_pkg::pwl_state_type              state_ff, state_in;
   pwl_pkg::pwl_src_type                src_ff, src_in;
   logic [pwl_pkg::IdxWidth-1:0]        idx_ff, idx_in;
   logic [pwl_pkg::CountWidth-1:0]      count_ff, count_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [pwl_pkg::CountWidth-1:0]      n_eff;
   logic [pwl_pkg::CountWidth-1:0]      idx_ext;
   logic [pwl_pkg::CountWidth-1:0]      idx_next;
   logic                                out_free;

   // Clamp the point count to the table size
   assign n_eff = (count_ff > pwl_pkg::CountWidth'(pwl_pkg::MaxPoints))
                  ? pwl_pkg::CountWidth'(pwl_pkg::MaxPoints) : count_ff;
   assign idx_ext  = pwl_pkg::CountWidth'(idx_ff);
   assign idx_next = idx_ext + 1'b1;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      src_in       = src_ff;
      idx_in       = idx_ff;
      count_in     = csr_we ? csr_wdata : count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         pwl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_mode == pwl_pkg::ModeWrite) begin
                  cmd.mem_we = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  if (n_eff == '0) begin
                     src_in   = pwl_pkg::SRC_ONE;
                     state_in = pwl_pkg::ST_OUT;
                  end else begin
                     cmd.rd_en   = 1'b1;
                     cmd.rd_addr = '0;
                     idx_in      = '0;
                     state_in    = pwl_pkg::ST_SCAN;
                  end
               end
            end
         end
         pwl_pkg::ST_SCAN: begin
            if (stat.le) begin
               if (idx_ff == '0) begin
                  src_in   = pwl_pkg::SRC_CUR;
                  state_in = pwl_pkg::ST_OUT;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = pwl_pkg::ST_DIV;
               end
            end else if (idx_next == n_eff) begin
               // past the last breakpoint: keep its value
               src_in   = pwl_pkg::SRC_CUR;
               state_in = pwl_pkg::ST_OUT;
            end else begin
               cmd.prev_load = 1'b1;
               cmd.rd_en     = 1'b1;
               cmd.rd_addr   = idx_next[pwl_pkg::IdxWidth-1:0];
               idx_in        = idx_next[pwl_pkg::IdxWidth-1:0];
            end
         end
         pwl_pkg::ST_DIV: begin
            if (!stat.div_busy) begin
               state_in = pwl_pkg::ST_MUL;
            end
         end
         pwl_pkg::ST_MUL: begin
            cmd.mul_load = 1'b1;
            src_in       = pwl_pkg::SRC_INTERP;
            state_in     = pwl_pkg::ST_OUT;
         end
         pwl_pkg::ST_OUT: begin
            // wait for the output register to drain
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_src  = src_ff;
               rsp_valid_in = 1'b1;
               state_in     = pwl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pwl_pkg::ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pwl_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         src_ff       <= pwl_pkg::SRC_ONE;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         src_ff       <= src_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `PWL_ASSERT_NEXT(a_empty_gives_one, clock, reset, state_ff == pwl_pkg::ST_IDLE && req_valid && req_mode == pwl_pkg::ModeEval && n_eff == '0, state_ff == pwl_pkg::ST_OUT && src_ff == pwl_pkg::SRC_ONE)
   `PWL_ASSERT(a_scan_in_range, clock, reset, state_ff == pwl_pkg::ST_SCAN |-> idx_ext < n_eff)
   `PWL_ASSERT(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == pwl_pkg::ST_OUT))

endmodule

`default_nettype wire

// File: rtl/piecewise_linear_curve_eval_top.sv
`default_nettype none
// Piecewise linear curve evaluator, signed Q16.16.
// csr_we/csr_wdata set the number of breakpoints in use (0 to 16; larger
// values act as 16). Write it only while the block is idle.
// req_ch carries items: mode 0 writes point_time/point_value into slot
// point_index and gives no response; mode 1 evaluates at query_time and
// gives one factor on rsp_ch (1.0 when no breakpoints are in use).
// A write transfer completes in its accept cycle. An evaluate walks the
// table one breakpoint a cycle through its single read port, then runs a
// shift-subtract divider for the weight and a multiply step. The next
// item is taken the cycle after the result is loaded. The result sits in
// an output register, so new items are taken while it waits; a stalled
// receiver holds the evaluate after it in its final cycle until the
// register drains.
// Reset clears the point count and the response valid; table contents
// are left as they are and must be written before use.
module piecewise_linear_curve_eval_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [pwl_pkg::CountWidth-1:0]     csr_wdata,
   pwl_req_if.sink                                 req_ch,
   pwl_rsp_if.source                               rsp_ch
);

   pwl_pkg::pwl_cmd_type  cmd;
   pwl_pkg::pwl_stat_type stat;

   pwl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   pwl_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .wr_index   (req_ch.point_index),
      .wr_time    (req_ch.point_time),
      .wr_value   (req_ch.point_value),
      .query_time (req_ch.query_time),
      .factor     (rsp_ch.factor)
   );

endmodule

`default_nettype wire

// File: tb/sv/piecewise_linear_curve_eval_top_test.sv
`default_nettype none

module piecewise_linear_curve_eval_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic signed [pwl_pkg::DataWidth-1:0] QMin = 32'sh8000_0000;
   localparam logic signed [pwl_pkg::DataWidth-1:0] QMax = 32'sh7FFF_FFFF;
   localparam int ItemTarget    = 1350;
   localparam int SettleCycles  = 40;
   localparam int WatchdogLimit = 4000;

   typedef struct {
      logic                                 mode;
      logic [pwl_pkg::IdxWidth-1:0]         slot;
      logic signed [pwl_pkg::DataWidth-1:0] bp_time;
      logic signed [pwl_pkg::DataWidth-1:0] bp_value;
      logic signed [pwl_pkg::DataWidth-1:0] query;
   } curve_item_type;

   logic                           clock;
   logic                           reset;
   logic                           csr_we;
   logic [pwl_pkg::CountWidth-1:0] csr_wdata;

   pwl_req_if req_ch ();
   pwl_rsp_if rsp_ch ();

   piecewise_linear_curve_eval_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   // Predictor state: breakpoint table as seen by accepted transfers, and the point count
   logic signed [pwl_pkg::DataWidth-1:0] curve_time  [pwl_pkg::MaxPoints] = '{default: '0};
   logic signed [pwl_pkg::DataWidth-1:0] curve_value [pwl_pkg::MaxPoints] = '{default: '0};
   logic [pwl_pkg::CountWidth-1:0]       curve_count = '0;

   // Stimulus-side copy of the breakpoint times, updated as items are queued
   logic signed [pwl_pkg::DataWidth-1:0] plan_time  [pwl_pkg::MaxPoints] = '{default: '0};

   curve_item_type                       item_backlog [$];
   logic signed [pwl_pkg::DataWidth-1:0] factor_due [$];
   int unsigned                          items_pushed = 0;
   int unsigned                          items_taken  = 0;
   int unsigned                          mismatches   = 0;

   // Interpolated factor for a query against the current table
   function automatic logic signed [pwl_pkg::DataWidth-1:0] curve_factor(
      logic signed [pwl_pkg::DataWidth-1:0] q
   );
      int unsigned used;
      longint      t0, t1, v0, v1, span, weight, sum;
      used = (curve_count > pwl_pkg::MaxPoints) ? pwl_pkg::MaxPoints : curve_count;
      if (used == 0) return pwl_pkg::FactorOne;
      if (q <= curve_time[0]) return curve_value[0];
      for (int i = 1; i < used; i++) begin
         if (q <= curve_time[i]) begin
            t0 = curve_time[i-1];
            t1 = curve_time[i];
            v0 = curve_value[i-1];
            v1 = curve_value[i];
            span = t1 - t0;
            weight = 0;
            if (span > 0) weight = ((longint'(q) - t0) <<< pwl_pkg::FracBits) / span;
            // floor rounding of the scaled difference
            sum = v0 + (((v1 - v0) * weight) >>> pwl_pkg::FracBits);
            return sum[pwl_pkg::DataWidth-1:0];
         end
      end
      return curve_value[used-1];
   endfunction

   function automatic logic signed [pwl_pkg::DataWidth-1:0] rand32();
      case ($urandom_range(0, 15))
         0:       return QMin;
         1:       return QMax;
         default: return $urandom;
      endcase
   endfunction

   function automatic void push_write(int unsigned slot,
                                      logic signed [pwl_pkg::DataWidth-1:0] t,
                                      logic signed [pwl_pkg::DataWidth-1:0] v);
      curve_item_type it;
      it.mode     = pwl_pkg::ModeWrite;
      it.slot     = pwl_pkg::IdxWidth'(slot);
      it.bp_time  = t;
      it.bp_value = v;
      it.query    = rand32();
      plan_time[slot] = t;
      item_backlog.push_back(it);
      items_pushed++;
   endfunction

   function automatic void push_eval(logic signed [pwl_pkg::DataWidth-1:0] q);
      curve_item_type it;
      it.mode     = pwl_pkg::ModeEval;
      it.slot     = pwl_pkg::IdxWidth'($urandom);
      it.bp_time  = rand32();
      it.bp_value = rand32();
      it.query    = q;
      item_backlog.push_back(it);
      items_pushed++;
   endfunction

   task automatic wait_drained();
      do @(posedge clock);
      while (items_taken != items_pushed || factor_due.size() != 0);
   endtask

   // Change the point count once the block has gone quiet
   task automatic set_point_count(logic [pwl_pkg::CountWidth-1:0] cnt);
      wait_drained();
      repeat (SettleCycles) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= cnt;
      @(posedge clock);
      csr_we    <= 1'b0;
      curve_count = cnt;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Request driver: one item per transfer, random gap before the next
   curve_item_type on_bus;
   curve_item_type next_item;
   int unsigned    send_hold = 0;
   bit             send_gaps = 1'b1;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_hold    <= 0;
      end else begin
         // update the predictor on the transfer completing at this edge
         if (req_ch.valid && req_ch.ready) begin
            if (on_bus.mode == pwl_pkg::ModeWrite) begin
               curve_time[on_bus.slot]  = on_bus.bp_time;
               curve_value[on_bus.slot] = on_bus.bp_value;
            end else begin
               factor_due.push_back(curve_factor(on_bus.query));
            end
            items_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_hold != 0) begin
               req_ch.valid <= 1'b0;
               send_hold    <= send_hold - 1;
            end else if (item_backlog.size() != 0) begin
               next_item = item_backlog.pop_front();
               on_bus             <= next_item;
               req_ch.mode        <= next_item.mode;
               req_ch.point_index <= next_item.slot;
               req_ch.point_time  <= next_item.bp_time;
               req_ch.point_value <= next_item.bp_value;
               req_ch.query_time  <= next_item.query;
               req_ch.valid       <= 1'b1;
               if ($urandom_range(0, 39) == 0) send_gaps = !send_gaps;
               send_hold <= send_gaps ? $urandom_range(0, 17) : 0;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each factor, then stall for a random spell
   logic signed [pwl_pkg::DataWidth-1:0] want;
   int unsigned                          recv_hold = 0;
   int unsigned                          recv_draw;
   bit                                   recv_gaps = 1'b1;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_hold    <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         if (factor_due.size() == 0) begin
            $error("factor: expected none, actual %0d", rsp_ch.factor);
            mismatches++;
         end else begin
            want = factor_due.pop_front();
            if (rsp_ch.factor !== want) begin
               $error("factor: expected %0d, actual %0d", want, rsp_ch.factor);
               mismatches++;
            end
         end
         if ($urandom_range(0, 39) == 0) recv_gaps = !recv_gaps;
         recv_draw = recv_gaps ? $urandom_range(0, 17) : 0;
         recv_hold    <= recv_draw;
         rsp_ch.ready <= (recv_draw == 0);
      end else if (recv_hold != 0) begin
         recv_hold    <= recv_hold - 1;
         rsp_ch.ready <= (recv_hold == 1);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Abort when neither channel has moved for too long
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WatchdogLimit) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic signed [pwl_pkg::DataWidth-1:0] q;
      logic [pwl_pkg::CountWidth-1:0]       cnt;
      longint                               stamps [$];
      int unsigned                          slots [$];
      int unsigned                          used, shape, seg, phase;
      longint                               t0, span, walk;

      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.mode        = pwl_pkg::ModeWrite;
      req_ch.point_index = '0;
      req_ch.point_time  = '0;
      req_ch.point_value = '0;
      req_ch.query_time  = '0;
      rsp_ch.ready       = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Empty curve straight out of reset
      push_eval(QMin);
      push_eval(QMax);

      // Four points spanning the full time range, with a repeated time
      set_point_count(4);
      push_write(0, QMin, QMax);
      push_write(1, -32'sd65536, QMin);
      push_write(2, -32'sd65536, 32'sd100);
      push_write(3, QMax, -32'sd5);
      push_eval(QMin);
      push_eval(QMin + 1);
      push_eval(-32'sd65536);
      push_eval(-32'sd65535);
      push_eval(32'sd0);
      push_eval(QMax);

      // Two points: half weight on a falling segment, then either clamp
      set_point_count(2);
      push_write(0, 32'sd0, 32'sd196608);
      push_write(1, 32'sd10, -32'sd458752);
      push_eval(32'sd5);
      push_eval(32'sd11);
      push_eval(-32'sd1);

      // Single point: every query clamps to it
      set_point_count(1);
      push_eval(-32'sd5);
      push_eval(32'sd0);
      push_eval(32'sd5);

      // Random phases, each with its own count and a freshly loaded table
      phase = 0;
      while (items_pushed < ItemTarget) begin
         case (phase)
            0:       cnt = pwl_pkg::CountWidth'(pwl_pkg::MaxPoints);
            1:       cnt = '1;
            2:       cnt = '0;
            3:       cnt = pwl_pkg::CountWidth'(pwl_pkg::MaxPoints + 1);
            default: begin
               case ($urandom_range(0, 9))
                  0:       cnt = '0;
                  1:       cnt = pwl_pkg::CountWidth'($urandom_range(pwl_pkg::MaxPoints + 1, 31));
                  default: cnt = pwl_pkg::CountWidth'($urandom_range(1, pwl_pkg::MaxPoints));
               endcase
            end
         endcase
         phase++;
         set_point_count(cnt);
         used = (cnt > pwl_pkg::MaxPoints) ? pwl_pkg::MaxPoints : cnt;

         // load every slot below the count: sorted, clustered or disordered times
         stamps.delete();
         slots.delete();
         shape = $urandom_range(0, 9);
         walk  = longint'(rand32() >>> 2);
         for (int i = 0; i < used; i++) begin
            slots.push_back(i);
            if (shape < 5) begin
               stamps.push_back(longint'(rand32()));
            end else if (shape < 8) begin
               walk += $urandom_range(1, 1 << 19);
               stamps.push_back(walk);
            end else if (i != 0 && $urandom_range(0, 2) == 0) begin
               stamps.push_back(stamps[i-1]);
            end else begin
               stamps.push_back(longint'(rand32()));
            end
         end
         if (shape < 5) stamps.sort();
         if ($urandom_range(0, 1) == 0) slots.shuffle();
         foreach (slots[k]) push_write(slots[k], stamps[slots[k]][31:0], rand32());

         // mostly evaluates aimed at the table, some stray writes
         repeat ($urandom_range(20, 60)) begin
            if ($urandom_range(0, 6) == 0) begin
               push_write($urandom_range(0, pwl_pkg::MaxPoints - 1), rand32(), rand32());
            end else begin
               seg = (used == 0) ? 0 : $urandom_range(0, used - 1);
               case ($urandom_range(0, 9))
                  0: q = rand32();
                  1: q = plan_time[seg] + $urandom_range(0, 2) - 1;
                  2: q = (used == 0) ? rand32()
                                     : plan_time[used-1] + $urandom_range(1, 4096);
                  3: q = plan_time[0] - $urandom_range(0, 4096);
                  default: begin
                     q = rand32();
                     if (seg != 0) begin
                        t0   = plan_time[seg-1];
                        span = longint'(plan_time[seg]) - t0;
                        if (span > 0)
                           q = 32'(t0 + (longint'({$urandom, $urandom} >> 1) % (span + 1)));
                     end
                  end
               endcase
               push_eval(q);
            end
         end
      end

      wait_drained();
      repeat (SettleCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/pwl_pkg.sv
rtl/pwl_if.sv
rtl/pwl_div.sv
rtl/pwl_dp.sv
rtl/pwl_ctrl.sv
rtl/piecewise_linear_curve_eval_top.sv
tb/sv/piecewise_linear_curve_eval_top_test.sv
